// ----- src/mouse_packet_cursor_tracker_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the mouse packet cursor tracker
// Two property shapes: same-cycle implication and next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef MOUSE_PACKET_CURSOR_TRACKER_TOP_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPCT_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPCT_ASSERT_NXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mpct_pkg.sv -----
// ---------------------------------------------------------------------------
// mpct_pkg
// Shared types and constants for the mouse packet cursor tracker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpct_pkg;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 13;
  localparam int IN_DATA_BITS   = 32;
  localparam int WHEEL_BITS     = 16;
  localparam int BUTTON_BITS    = 5;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 8'd1;

  localparam logic [CFG_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd480;

  // Decoded packet
  typedef struct packed {
    logic signed [8:0]             dx;
    logic signed [8:0]             dy;
    logic signed [3:0]             dz;
    logic [BUTTON_BITS-1:0]        buttons;
  } pkt_t;

endpackage

`default_nettype wire

// ----- src/mpct_cfg.sv -----
// ---------------------------------------------------------------------------
// mpct_cfg
// Screen size registers, held as the largest legal cursor coordinate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpct_cfg #(
  parameter int COORD_BITS = 12
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_valid,
  input  wire  [mpct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [mpct_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic [COORD_BITS-1:0]               lim_x,
  output logic [COORD_BITS-1:0]               lim_y
);
  import mpct_pkg::*;

  localparam int LW = (COORD_BITS > CFG_DATA_BITS) ? COORD_BITS : CFG_DATA_BITS;
  localparam logic [LW-1:0] CAP = LW'((33'd1 << COORD_BITS) - 33'd1);

  // Size zero acts as one; anything beyond the coordinate range saturates
  function automatic logic [COORD_BITS-1:0] axis_limit(input logic [CFG_DATA_BITS-1:0] size);
    logic [CFG_DATA_BITS-1:0] lim;
    logic [LW-1:0]            lim_ext;
    lim     = (size == '0) ? '0 : size - 1'b1;
    lim_ext = LW'(lim);
    if (lim_ext > CAP) begin
      lim_ext = CAP;
    end
    return lim_ext[COORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_x <= axis_limit(SCREEN_WIDTH_RESET);
      lim_y <= axis_limit(SCREEN_HEIGHT_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  lim_x <= axis_limit(cfg_data);
        REG_SCREEN_HEIGHT: lim_y <= axis_limit(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/mpct_decode.sv -----
// ---------------------------------------------------------------------------
// mpct_decode
// Split a four-byte wheel-mouse packet into movements and buttons.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpct_decode (
  input  wire  [mpct_pkg::IN_DATA_BITS-1:0] packet,
  output mpct_pkg::pkt_t                    pkt
);
  import mpct_pkg::*;

  logic [7:0] status_byte;
  logic [7:0] x_move_byte;
  logic [7:0] y_move_byte;
  logic [7:0] wheel_byte;

  assign status_byte = packet[7:0];
  assign x_move_byte = packet[15:8];
  assign y_move_byte = packet[23:16];
  assign wheel_byte  = packet[31:24];

  // Sign bits for X and Y live in the status byte
  always_comb begin
    pkt.dx      = $signed({status_byte[4], x_move_byte});
    pkt.dy      = $signed({status_byte[5], y_move_byte});
    pkt.dz      = $signed(wheel_byte[3:0]);
    pkt.buttons = {wheel_byte[5:4], status_byte[2:0]};
  end

endmodule

`default_nettype wire

// ----- src/mpct_axis.sv -----
// ---------------------------------------------------------------------------
// mpct_axis
// Move one cursor axis by a signed step and clamp it to [0, limit].
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpct_axis #(
  parameter int COORD_BITS = 12,
  parameter bit SUBTRACT   = 1'b0
) (
  input  wire  [COORD_BITS-1:0] pos,
  input  wire  signed [8:0]     delta,
  input  wire  [COORD_BITS-1:0] lim,
  output logic [COORD_BITS-1:0] pos_next
);

  logic signed [COORD_BITS+1:0] pos_ext;
  logic signed [COORD_BITS+1:0] delta_ext;
  logic signed [COORD_BITS+1:0] sum;

  assign pos_ext   = $signed({2'b00, pos});
  assign delta_ext = (COORD_BITS + 2)'(delta);
  assign sum       = SUBTRACT ? pos_ext - delta_ext : pos_ext + delta_ext;

  always_comb begin
    if (sum[COORD_BITS+1]) begin
      pos_next = '0;
    end else if (sum[COORD_BITS:0] > {1'b0, lim}) begin
      pos_next = lim;
    end else begin
      pos_next = sum[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- src/mouse_packet_cursor_tracker_top.sv -----
// ---------------------------------------------------------------------------
// mouse_packet_cursor_tracker_top
// Decode four-byte wheel-mouse packets and track a clamped cursor and wheel.
// ---------------------------------------------------------------------------
//
//   channel   | ports                 | one item
//   ----------+-----------------------+------------------------------------
//   packet in | s_axis_t{valid,ready} | status, x, y and wheel bytes
//   result    | m_axis_t{valid,ready} | cursor x/y, wheel total, buttons
//   config    | cfg_{valid,ready}     | index 0 width, 1 height
//
// One item per cycle sustained while the result side does not stall; each
// packet passes the input register, then the state/result registers.
// The per-item add and clamp reads the cursor state left by the previous
// item, so that state feedback path sets the cycle time.
// Reset (rst, synchronous): cursor and wheel go to zero, screen 640 x 480.
// A stalled result holds the result register; one more packet waits in the
// input register, and the input stalls only when both are full.
//
`timescale 1ns / 1ps
`default_nettype none
`include "mouse_packet_cursor_tracker_top_assert.svh"

module mouse_packet_cursor_tracker_top #(
  parameter int COORD_BITS = 12
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // packet in
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] status_byte, [15:8] x_move_byte, [23:16] y_move_byte,
  // [31:24] wheel_byte
  input  wire  [mpct_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // result out
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // from bit 0: cursor_x, cursor_y (COORD_BITS each), wheel_total (16),
  // button_mask (5), zero padding to whole bytes
  output logic [((2*COORD_BITS+21+7)/8)*8-1:0] m_axis_tdata,
  // configuration writes
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [mpct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [mpct_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mpct_pkg::*;

  localparam int OUT_BITS = 2*COORD_BITS + WHEEL_BITS + BUTTON_BITS;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Input register
  logic                    in_full;
  logic [IN_DATA_BITS-1:0] in_data;

  // State, which is also the result register
  logic [COORD_BITS-1:0]        pos_x;
  logic [COORD_BITS-1:0]        pos_y;
  logic signed [WHEEL_BITS-1:0] wheel_sum;
  logic [BUTTON_BITS-1:0]       buttons;

  logic [COORD_BITS-1:0]        pos_x_next;
  logic [COORD_BITS-1:0]        pos_y_next;
  logic signed [WHEEL_BITS-1:0] wheel_sum_next;
  logic signed [WHEEL_BITS:0]   wheel_wide;

  logic [COORD_BITS-1:0] lim_x;
  logic [COORD_BITS-1:0] lim_y;

  pkt_t pkt;
  logic advance;

  // Move the held packet on whenever the result slot is free or being taken
  assign advance       = in_full && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_full || advance;
  assign cfg_ready     = 1'b1;

  mpct_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lim_x     (lim_x),
    .lim_y     (lim_y)
  );

  mpct_decode u_decode (
    .packet (in_data),
    .pkt    (pkt)
  );

  // X adds the movement; Y subtracts it (mouse Y is up, screen Y is down)
  mpct_axis #(
    .COORD_BITS (COORD_BITS),
    .SUBTRACT   (1'b0)
  ) u_axis_x (
    .pos      (pos_x),
    .delta    (pkt.dx),
    .lim      (lim_x),
    .pos_next (pos_x_next)
  );

  mpct_axis #(
    .COORD_BITS (COORD_BITS),
    .SUBTRACT   (1'b1)
  ) u_axis_y (
    .pos      (pos_y),
    .delta    (pkt.dy),
    .lim      (lim_y),
    .pos_next (pos_y_next)
  );

  // Saturating wheel total
  assign wheel_wide = (WHEEL_BITS + 1)'(wheel_sum) + (WHEEL_BITS + 1)'(pkt.dz);

  always_comb begin
    if (wheel_wide[WHEEL_BITS] != wheel_wide[WHEEL_BITS-1]) begin
      wheel_sum_next = wheel_wide[WHEEL_BITS] ? {1'b1, {(WHEEL_BITS-1){1'b0}}}
                                              : {1'b0, {(WHEEL_BITS-1){1'b1}}};
    end else begin
      wheel_sum_next = wheel_wide[WHEEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      wheel_sum     <= '0;
    end else begin
      // hold a packet until it moves on
      if (s_axis_tvalid && s_axis_tready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        m_axis_tvalid <= 1'b1;
        pos_x         <= pos_x_next;
        pos_y         <= pos_y_next;
        wheel_sum     <= wheel_sum_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
    if (advance) begin
      buttons <= pkt.buttons;
    end
  end

  assign m_axis_tdata = OUT_W'({buttons, wheel_sum, pos_y, pos_x});

  // ---- assertions ----
  `MPCT_ASSERT_IMP(a_stall_cause, clk, rst, !s_axis_tready,
    in_full && m_axis_tvalid && !m_axis_tready,
    "input stalled without both registers full")
  `MPCT_ASSERT_NXT(a_x_in_screen, clk, rst, advance, pos_x <= $past(lim_x),
    "cursor x beyond screen limit")
  `MPCT_ASSERT_NXT(a_y_in_screen, clk, rst, advance, pos_y <= $past(lim_y),
    "cursor y beyond screen limit")
  `MPCT_ASSERT_NXT(a_wheel_up, clk, rst, advance && !pkt.dz[3],
    $signed(wheel_sum) >= $signed($past(wheel_sum)),
    "wheel total fell on a non-negative step")
  `MPCT_ASSERT_NXT(a_reset_quiet, clk, 1'b0, rst, !m_axis_tvalid && !in_full,
    "result or packet held across reset")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - mouse packet cursor tracker testbench
// Drives four-byte pointer packets and screen size writes into the tracker,
// predicts cursor, wheel total and buttons for every packet, and compares
// each result item field by field while both stream sides stall at random.
// ---------------------------------------------------------------------------

module tb_top;
  import mpct_pkg::*;

  localparam int COORD_MAX    = 4095;
  localparam int WHEEL_MAX    = 32767;
  localparam int WHEEL_MIN    = -32768;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;

  // Any index past the last real register is ignored by the block
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = REG_SCREEN_HEIGHT + 8'd1;

  // One input item, status byte in the lowest bits
  typedef struct packed {
    logic [7:0] wheel_byte;
    logic [7:0] y_move_byte;
    logic [7:0] x_move_byte;
    logic [7:0] status_byte;
  } packet_t;

  // One result item, cursor x in the lowest bits, zero padding on top
  typedef struct packed {
    logic [2:0]         pad;
    logic [4:0]         button_mask;
    logic signed [15:0] wheel_total;
    logic [11:0]        cursor_y;
    logic [11:0]        cursor_x;
  } report_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  mouse_packet_cursor_tracker_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Packets waiting to be offered, and reports the tracker still owes us
  packet_t packet_q[$];
  report_t cursor_reports_q[$];

  // Our own copy of the tracker state and screen size
  int trk_x, trk_y, trk_wheel;
  int scr_w, scr_h;

  int send_idle_pct, recv_idle_pct;
  bit in_fire;
  int packets_taken, reports_checked, reg_writes, error_count, cycle_count;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // Largest cursor coordinate for a screen dimension: zero acts like one,
  // oversized screens saturate at the coordinate range
  function automatic int axis_top(input int size);
    int lim;
    lim = (size == 0) ? 0 : size - 1;
    if (lim > COORD_MAX) lim = COORD_MAX;
    return lim;
  endfunction

  function automatic int clamp_axis(input int v, input int lim);
    if (v < 0) return 0;
    if (v > lim) return lim;
    return v;
  endfunction

  // Advance the tracked cursor and wheel by one packet and return the report
  function automatic report_t track_packet(input packet_t p);
    logic signed [8:0] sx, sy;
    logic signed [3:0] sz;
    int nz;
    report_t r;
    sx = {p.status_byte[4], p.x_move_byte};
    sy = {p.status_byte[5], p.y_move_byte};
    sz = p.wheel_byte[3:0];
    // Screen y grows downwards, so a positive mouse y moves the cursor up
    trk_x = clamp_axis(trk_x + int'(sx), axis_top(scr_w));
    trk_y = clamp_axis(trk_y - int'(sy), axis_top(scr_h));
    nz = trk_wheel + int'(sz);
    if (nz > WHEEL_MAX) nz = WHEEL_MAX;
    else if (nz < WHEEL_MIN) nz = WHEEL_MIN;
    trk_wheel = nz;
    r.pad         = '0;
    r.cursor_x    = trk_x[11:0];
    r.cursor_y    = trk_y[11:0];
    r.wheel_total = trk_wheel[15:0];
    r.button_mask = {p.wheel_byte[5:4], p.status_byte[2:0]};
    return r;
  endfunction

  // Build a well-formed packet from signed movements and a button mask
  function automatic packet_t make_packet(input int dx, input int dy, input int dz,
                                          input logic [4:0] btn);
    logic [8:0] ux, uy;
    logic [3:0] uz;
    packet_t p;
    ux = dx[8:0];
    uy = dy[8:0];
    uz = dz[3:0];
    p.status_byte = {2'b00, uy[8], ux[8], 1'b0, btn[2:0]};
    p.x_move_byte = ux[7:0];
    p.y_move_byte = uy[7:0];
    p.wheel_byte  = {2'b00, btn[4:3], uz};
    return p;
  endfunction

  // Mostly raw random bytes, some gentle moves, some hard pushes at an edge
  function automatic packet_t random_packet();
    int mode, sgn_x, sgn_y;
    mode = $urandom_range(9);
    if (mode <= 4) return packet_t'($urandom);
    if (mode <= 7)
      return make_packet(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                         int'($urandom_range(15)) - 8, 5'($urandom));
    sgn_x = $urandom_range(1) ? 1 : -1;
    sgn_y = $urandom_range(1) ? 1 : -1;
    return make_packet(sgn_x * int'($urandom_range(255, 200)),
                       sgn_y * int'($urandom_range(255, 200)),
                       int'($urandom_range(15)) - 8, 5'($urandom));
  endfunction

  // Screen dimension: zero, one, the legal top, oversized or ordinary
  function automatic logic [CFG_DATA_BITS-1:0] pick_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 13'd1;
      2:       return 13'd4096;
      3:       return '1;
      4:       return 13'($urandom_range(8191, 4097));
      5, 6:    return 13'($urandom_range(64, 1));
      default: return 13'($urandom_range(4096, 1));
    endcase
  endfunction

  // Offer one register write and mirror it into our copy once taken
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = val;
      REG_SCREEN_HEIGHT: scr_h = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued packet has gone in and every report has come out
  task automatic wait_idle();
    @(posedge clk);
    while (packet_q.size() != 0 || s_axis_tvalid || cursor_reports_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure();
    if ($urandom_range(3) != 0) write_reg(REG_SCREEN_WIDTH, pick_size());
    if ($urandom_range(3) != 0) write_reg(REG_SCREEN_HEIGHT, pick_size());
    if ($urandom_range(4) == 0)
      write_reg(CFG_INDEX_BITS'($urandom_range(255, int'(REG_FIRST_UNUSED))),
                CFG_DATA_BITS'($urandom));
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Packet driver: change inputs on the falling edge, advance only once the
  // current item has been taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (packet_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= packet_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: on each rising edge predict for a taken packet and check a
  // delivered report against the oldest expectation
  always @(posedge clk) begin
    report_t got, want;
    in_fire = !rst && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      cursor_reports_q.push_back(track_packet(packet_t'(s_axis_tdata)));
      packets_taken++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = report_t'(m_axis_tdata);
      if (cursor_reports_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected report, expected none, got %h", $time, m_axis_tdata);
      end else begin
        want = cursor_reports_q.pop_front();
        report_field("cursor_x", want.cursor_x, got.cursor_x);
        report_field("cursor_y", want.cursor_y, got.cursor_y);
        report_field("wheel_total", want.wheel_total, got.wheel_total);
        report_field("button_mask", want.button_mask, got.button_mask);
        report_field("padding", want.pad, got.pad);
        reports_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_fire       = 1'b0;
    trk_x         = 0;
    trk_y         = 0;
    trk_wheel     = 0;
    scr_w         = SCREEN_WIDTH_RESET;
    scr_h         = SCREEN_HEIGHT_RESET;
    send_idle_pct = 34;
    recv_idle_pct = 86;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: run on the reset screen first, exercising every field edge
    packet_q.push_back(make_packet(0, 0, 0, 5'b00000));
    packet_q.push_back(make_packet(255, 0, 7, 5'b00001));
    packet_q.push_back(make_packet(-256, 0, -8, 5'b00010));
    packet_q.push_back(make_packet(0, 255, 0, 5'b00100));
    packet_q.push_back(make_packet(0, -256, 0, 5'b01000));
    packet_q.push_back(make_packet(255, -256, 1, 5'b10000));
    packet_q.push_back(make_packet(255, -256, -1, 5'b11111));
    packet_q.push_back(make_packet(255, -256, 0, 5'b00000));
    // Every byte all ones: one step back on each axis and the wheel
    packet_q.push_back(packet_t'(32'hFFFF_FFFF));
    // Spare status and wheel bits must be ignored
    packet_q.push_back(packet_t'{wheel_byte: 8'hC0, y_move_byte: 8'h00,
                                 x_move_byte: 8'h00, status_byte: 8'hC8});
    wait_idle();

    // Oversized screen: drive the cursor into the far corner of the range
    write_reg(REG_SCREEN_WIDTH, '1);
    write_reg(REG_SCREEN_HEIGHT, '1);
    repeat (15) packet_q.push_back(make_packet(255, -256, 0, 5'b00000));
    wait_idle();

    // Shrink the screen under the cursor, with a zero height on top
    write_reg(REG_SCREEN_WIDTH, 13'd100);
    write_reg(REG_SCREEN_HEIGHT, '0);
    packet_q.push_back(make_packet(0, 0, 0, 5'b00000));
    wait_idle();

    // A write to an unused index must leave the screen alone
    write_reg(REG_FIRST_UNUSED, 13'd5);
    write_reg('1, 13'd7);
    packet_q.push_back(make_packet(3, -3, 0, 5'b00000));
    wait_idle();

    // Random: three idling regimes, screen changed between batches
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 34; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int batch = 0; batch < 5; batch++) begin
        reconfigure();
        repeat ((phase == 2) ? 90 : 100) packet_q.push_back(random_packet());
        wait_idle();
      end
    end

    if (cursor_reports_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d reports never arrived", $time, cursor_reports_q.size());
    end

    $display("Ran %0d packets and %0d register writes, %0d reports compared",
             packets_taken, reg_writes, reports_checked);
    $display("Screens from zero to oversized, three stall regimes on both sides");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
